[hdl/can_bit_timing_calculator_core_defines.svh]
// Assertion macros shared by the bit timing calculator RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef CAN_BIT_TIMING_CALCULATOR_CORE_DEFINES_SVH
`define CAN_BIT_TIMING_CALCULATOR_CORE_DEFINES_SVH

`define CBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cbt_pkg.sv]
// Package for the CAN bit timing calculator: widths, constants, codes,
// controller state type, command struct and the reciprocal table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned QUANTA_W    = 5;
    localparam int unsigned PRESC_W     = 10;
    localparam int unsigned SEG1_W      = 4;
    localparam int unsigned SEG2_W      = 1;
    localparam int unsigned SJW_W       = 2;
    localparam int unsigned STATUS_W    = 2;

    localparam int unsigned QUANTA_MAX      = 18;
    localparam int unsigned QUANTA_FALLBACK = 9;
    localparam int unsigned QUANTA_COUNT    = QUANTA_MAX - QUANTA_FALLBACK + 1;
    localparam int unsigned SEG2_SHIFT      = 3;
    localparam int unsigned JUMP_WIDTH      = 2;
    localparam int unsigned PRESCALER_MAX   = 1024;

    localparam int unsigned BIG_LIMIT   = (PRESCALER_MAX + 1) * QUANTA_MAX;
    localparam int unsigned SMALL_W     = 15;
    localparam int unsigned RECIP_SHIFT = 21;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned PROD_W      = SMALL_W + RECIP_W;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int unsigned RECIP_ONE   = 2 ** RECIP_SHIFT;

    localparam int unsigned DIV_STEPS   = DATA_W;
    localparam int unsigned CNT_W       = 6;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RATE_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SEARCH,
        ST_WRITE
    } cbt_state_t;

    typedef struct packed {
        logic                load;
        logic                div_step;
        logic                issue;
        logic [QUANTA_W-1:0] quanta;
        logic                finish;
    } cbt_cmd_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [QUANTA_W-1:0] q);
        logic [RECIP_W-1:0] r;
        case (q)
            5'd9:    r = RECIP_W'((RECIP_ONE + 8) / 9);
            5'd10:   r = RECIP_W'((RECIP_ONE + 9) / 10);
            5'd11:   r = RECIP_W'((RECIP_ONE + 10) / 11);
            5'd12:   r = RECIP_W'((RECIP_ONE + 11) / 12);
            5'd13:   r = RECIP_W'((RECIP_ONE + 12) / 13);
            5'd14:   r = RECIP_W'((RECIP_ONE + 13) / 14);
            5'd15:   r = RECIP_W'((RECIP_ONE + 14) / 15);
            5'd16:   r = RECIP_W'((RECIP_ONE + 15) / 16);
            5'd17:   r = RECIP_W'((RECIP_ONE + 16) / 17);
            5'd18:   r = RECIP_W'((RECIP_ONE + 17) / 18);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/cbt_in_if.sv]
// Input channel of the bit timing calculator: clock and bit rate request.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cbt_in_if
    import cbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] clock_hz;
    logic [DATA_W-1:0] bit_rate;

    modport source (output valid, output clock_hz, output bit_rate, input ready);
    modport sink (input valid, input clock_hz, input bit_rate, output ready);
endinterface

`default_nettype wire

[hdl/cbt_out_if.sv]
// Output channel of the bit timing calculator: timing codes and status.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cbt_out_if
    import cbt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [QUANTA_W-1:0] quanta_per_bit;
    logic [PRESC_W-1:0]  prescaler_code;
    logic [SEG1_W-1:0]   seg1_code;
    logic [SEG2_W-1:0]   seg2_code;
    logic [SJW_W-1:0]    jump_width_code;
    logic [DATA_W-1:0]   timing_word;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, output quanta_per_bit, output prescaler_code, output seg1_code,
        output seg2_code, output jump_width_code, output timing_word, output status,
        input ready
    );
    modport sink (
        input valid, input quanta_per_bit, input prescaler_code, input seg1_code,
        input seg2_code, input jump_width_code, input timing_word, input status,
        output ready
    );
endinterface

`default_nettype wire

[hdl/can_bit_timing_calculator_core.sv]
// Top level of the CAN bit timing calculator: controller plus datapath.
// Depends on cbt_pkg, cbt_in_if, cbt_out_if, cbt_controller, cbt_datapath.
//
//   Channel   Dir   Payload
//   in_ch     sink  clock_hz, bit_rate
//   out_ch    src   quanta_per_bit, prescaler_code, seg1_code, seg2_code,
//                   jump_width_code, timing_word, status
//
// A result is valid after its input transfer has passed 32 divider steps, the quanta
// sweep through the two-stage reciprocal pipeline and one result write; the next
// transfer is taken only once the result write has been done.
// Reset is asynchronous and active low; no clearing pass is needed.
// A waiting result does not stop the next transfer in; only the final write waits
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "can_bit_timing_calculator_core_defines.svh"

module can_bit_timing_calculator_core
    import cbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbt_in_if.sink    in_ch,
    cbt_out_if.source out_ch
);

    cbt_cmd_t cmd;
    logic     in_xfer;
    logic     out_ok;
    logic     out_err;
    logic     quanta_legal;
    logic     fields_zero;
    logic     slot_open;

    cbt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    cbt_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .clock_hz        (in_ch.clock_hz),
        .bit_rate        (in_ch.bit_rate),
        .quanta_per_bit  (out_ch.quanta_per_bit),
        .prescaler_code  (out_ch.prescaler_code),
        .seg1_code       (out_ch.seg1_code),
        .seg2_code       (out_ch.seg2_code),
        .jump_width_code (out_ch.jump_width_code),
        .timing_word     (out_ch.timing_word),
        .status          (out_ch.status)
    );

    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_ok       = out_ch.valid && (out_ch.status == STATUS_OK);
    assign out_err      = out_ch.valid && (out_ch.status != STATUS_OK);
    assign quanta_legal = (out_ch.quanta_per_bit >= QUANTA_W'(QUANTA_FALLBACK))
                       && (out_ch.quanta_per_bit <= QUANTA_W'(QUANTA_MAX));
    assign fields_zero  = (out_ch.timing_word == '0) && (out_ch.quanta_per_bit == '0);
    assign slot_open    = !out_ch.valid || out_ch.ready;

    `CBT_ASSERT_NEXT(a_busy_after_transfer, in_xfer, !in_ch.ready, "ready after transfer")
    `CBT_ASSERT_SAME(a_quanta_range, out_ok, quanta_legal, "quanta out of range")
    `CBT_ASSERT_SAME(a_error_zero_word, out_err, fields_zero, "error result not zero")
    `CBT_ASSERT_SAME(a_finish_needs_slot, cmd.finish, slot_open, "result overwritten")

endmodule

`default_nettype wire

[hdl/cbt_controller.sv]
// Sequencer for the bit timing calculator: divide, quanta sweep, result write.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbt_controller
    import cbt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output cbt_cmd_t      cmd
);

    cbt_state_t       state_reg;
    cbt_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == CNT_W'(QUANTA_COUNT))
                begin
                    cnt_next   = '0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.issue  = cnt_reg < CNT_W'(QUANTA_COUNT);
                cmd.quanta = QUANTA_W'(QUANTA_MAX) - cnt_reg[QUANTA_W-1:0];
            end
            ST_WRITE:
            begin
                cmd.finish = slot_free;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cbt_datapath.sv]
// Datapath of the bit timing calculator: restoring divider, reciprocal quanta
// test pipeline and result register. Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbt_datapath
    import cbt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbt_cmd_t            cmd,
    input  wire logic [DATA_W-1:0]   clock_hz,
    input  wire logic [DATA_W-1:0]   bit_rate,
    output logic [QUANTA_W-1:0]      quanta_per_bit,
    output logic [PRESC_W-1:0]       prescaler_code,
    output logic [SEG1_W-1:0]        seg1_code,
    output logic [SEG2_W-1:0]        seg2_code,
    output logic [SJW_W-1:0]         jump_width_code,
    output logic [DATA_W-1:0]        timing_word,
    output logic [STATUS_W-1:0]      status
);

    logic [DATA_W-1:0]   num_reg;
    logic [DATA_W-1:0]   den_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic                rate_zero_reg;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;

    logic [PROD_W-1:0]   prod_reg;
    logic [QUANTA_W-1:0] q1_reg;
    logic                v1_reg;
    logic [QUOT_W-1:0]   quot;
    logic [SMALL_W+1:0]  back;
    logic                hit;

    logic                found_reg;
    logic [QUANTA_W-1:0] qsel_reg;
    logic [QUOT_W-1:0]   presc_reg;

    logic                big;
    logic                bad_presc;
    logic [STATUS_W-1:0] status_next;
    logic [QUANTA_W-1:0] seg2;
    logic [QUANTA_W-1:0] seg1;
    logic [PRESC_W-1:0]  presc_code;
    logic [SEG1_W-1:0]   seg1_c;
    logic [SEG2_W-1:0]   seg2_c;
    logic [SJW_W-1:0]    sjw_c;

    logic [QUANTA_W-1:0] quanta_reg;
    logic [PRESC_W-1:0]  presc_code_reg;
    logic [SEG1_W-1:0]   seg1_code_reg;
    logic [SEG2_W-1:0]   seg2_code_reg;
    logic [SJW_W-1:0]    sjw_code_reg;
    logic [DATA_W-1:0]   word_reg;
    logic [STATUS_W-1:0] status_reg;

    assign shifted = {rem_reg, num_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg       <= clock_hz;
            den_reg       <= bit_rate;
            rem_reg       <= '0;
            rate_zero_reg <= (bit_rate == '0);
        end
        else if (cmd.div_step)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                num_reg <= {num_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                num_reg <= {num_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign quot = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign back = (SMALL_W+2)'(quot) * (SMALL_W+2)'(q1_reg);
    assign hit  = (back == {2'b00, num_reg[SMALL_W-1:0]});

    always_ff @(posedge clk)
    begin
        prod_reg <= num_reg[SMALL_W-1:0] * recip(cmd.quanta);
        q1_reg   <= cmd.quanta;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && !found_reg)
        begin
            qsel_reg  <= q1_reg;
            presc_reg <= quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (v1_reg && (hit || q1_reg == QUANTA_W'(QUANTA_FALLBACK)))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign big        = (num_reg >= DATA_W'(BIG_LIMIT));
    assign bad_presc  = big || (presc_reg == '0) || (presc_reg > QUOT_W'(PRESCALER_MAX));
    assign seg2       = qsel_reg >> SEG2_SHIFT;
    assign seg1       = qsel_reg - seg2 - 1'b1;
    assign presc_code = PRESC_W'(presc_reg - 1'b1);
    assign seg1_c     = SEG1_W'(seg1 - 1'b1);
    assign seg2_c     = SEG2_W'(seg2 - 1'b1);
    assign sjw_c      = SJW_W'(JUMP_WIDTH - 1);

    always_comb
    begin
        if (rate_zero_reg)
        begin
            status_next = STATUS_RATE_ZERO;
        end
        else if (bad_presc)
        begin
            status_next = STATUS_RANGE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_OK)
            begin
                quanta_reg     <= qsel_reg;
                presc_code_reg <= presc_code;
                seg1_code_reg  <= seg1_c;
                seg2_code_reg  <= seg2_c;
                sjw_code_reg   <= sjw_c;
                word_reg       <= {6'b0, sjw_c, 1'b0, 3'(seg2 - 1'b1), seg1_c,
                                   6'b0, presc_code};
            end
            else
            begin
                quanta_reg     <= '0;
                presc_code_reg <= '0;
                seg1_code_reg  <= '0;
                seg2_code_reg  <= '0;
                sjw_code_reg   <= '0;
                word_reg       <= '0;
            end
        end
    end

    assign quanta_per_bit  = quanta_reg;
    assign prescaler_code  = presc_code_reg;
    assign seg1_code       = seg1_code_reg;
    assign seg2_code       = seg2_code_reg;
    assign jump_width_code = sjw_code_reg;
    assign timing_word     = word_reg;
    assign status          = status_reg;

endmodule

`default_nettype wire
